[hdl/psdl_pkg.sv]
// ----------------------------------------------------------------------------
// psdl_pkg
// Shared types and constants of the plucked string delay line.
// ----------------------------------------------------------------------------
package psdl_pkg;

  localparam int DEFAULT_DELAY_DEPTH = 4096;
  localparam int DEFAULT_QUEUE_DEPTH = 4;

  localparam int SAMPLE_W  = 16;
  localparam int DAMP_W    = 16;
  localparam int RATE_W    = 18;
  localparam int PITCH_W   = 19;
  localparam int AMOUNT_W  = 16;
  localparam int CFG_W     = 19;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_W     = 23;
  localparam int QUO_W     = NUM_W;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int SPAN_W    = 13;

  localparam int MIN_LOOP_LENGTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_HZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DAMPING = 2'd2;

  localparam logic [RATE_W-1:0]   RATE_RESET   = 18'd48000;
  localparam logic [PITCH_W-1:0]  PITCH_RESET  = 19'd7040;
  localparam logic [AMOUNT_W-1:0] AMOUNT_RESET = 16'd59578;

  localparam logic [PITCH_W-1:0] PITCH_FLOOR = 19'd320;
  localparam logic [DAMP_W-1:0]  DAMP_BASE   = 16'd58982;
  localparam logic [SPAN_W-1:0]  DAMP_SPAN   = 13'd6488;
  localparam logic [DAMP_W-1:0]  DAMP_RESET  = 16'd64880;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  typedef enum logic {
    FRONT_PASS,
    FRONT_DIV
  } front_state_t;

  typedef enum logic [1:0] {
    BACK_CLEAR,
    BACK_IDLE,
    BACK_READ,
    BACK_WRITE
  } back_state_t;

  typedef struct packed {
    op_t                        op;
    logic                       first;
    logic signed [SAMPLE_W-1:0] sample;
    logic [QUO_W-1:0]           quotient;
    logic [DAMP_W-1:0]          damping;
  } psdl_item_t;

endpackage

[hdl/psdl_in_if.sv]
// ----------------------------------------------------------------------------
// psdl_in_if
// Input channel: tick and excitation load items.
// ----------------------------------------------------------------------------
interface psdl_in_if import psdl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic                       first_of_excitation;
  logic signed [SAMPLE_W-1:0] excitation_sample;

  modport source (
    output valid, operation, first_of_excitation, excitation_sample,
    input  ready
  );

  modport sink (
    input  valid, operation, first_of_excitation, excitation_sample,
    output ready
  );
endinterface

[hdl/psdl_out_if.sv]
// ----------------------------------------------------------------------------
// psdl_out_if
// Output channel: string samples, one per tick.
// ----------------------------------------------------------------------------
interface psdl_out_if import psdl_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] string_sample;

  modport source (
    output valid, string_sample,
    input  ready
  );

  modport sink (
    input  valid, string_sample,
    output ready
  );
endinterface

[hdl/psdl_ram.sv]
// ----------------------------------------------------------------------------
// psdl_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module psdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hdl/psdl_div.sv]
// ----------------------------------------------------------------------------
// psdl_div
// Restoring divider for the loop length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module psdl_div import psdl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUM_W-1:0]   num,
  input  logic [PITCH_W-1:0] den,
  output logic               busy,
  output logic [QUO_W-1:0]   quo
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [PITCH_W-1:0]   rem;
  logic [PITCH_W-1:0]   divisor;
  logic [NUM_W-1:0]     numsh;
  logic [PITCH_W:0]     trial;
  logic [PITCH_W:0]     diff;
  logic                 ge;

  assign trial = {rem, numsh[NUM_W-1]};
  assign ge    = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= DIV_CNT_W'(NUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= '0;
      numsh   <= num;
      divisor <= den;
    end else if (busy) begin
      rem   <= ge ? diff[PITCH_W-1:0] : trial[PITCH_W-1:0];
      numsh <= {numsh[NUM_W-2:0], 1'b0};
      quo   <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

[hdl/psdl_queue.sv]
// ----------------------------------------------------------------------------
// psdl_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module psdl_queue import psdl_pkg::*; #(
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  psdl_item_t push_item,
  output logic       full,
  input  logic       pop,
  output psdl_item_t head,
  output logic       empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

  psdl_item_t        entries [QUEUE_DEPTH];
  logic [PW-1:0]     rd_ptr;
  logic [PW-1:0]     wr_ptr;
  logic [CW-1:0]     count;
  logic              do_push;
  logic              do_pop;

  assign full    = count == FULL_CNT;
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/psdl_front.sv]
// ----------------------------------------------------------------------------
// psdl_front
// Accepts items, holds the registers, works out length and damping on a pluck.
// ----------------------------------------------------------------------------
module psdl_front import psdl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  psdl_in_if.sink              request,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 clear_busy,
  input  logic                 q_full,
  output logic                 push,
  output psdl_item_t           push_item
);

  front_state_t               state;
  front_state_t               state_next;
  logic [RATE_W-1:0]          rate_hz;
  logic [PITCH_W-1:0]         pitch;
  logic [AMOUNT_W-1:0]        amount;
  logic                       held_valid;
  op_t                        held_op;
  logic                       held_first;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic [DAMP_W-1:0]          held_damp;
  logic                       accept;
  logic                       start;
  logic                       div_busy;
  logic [QUO_W-1:0]           div_quo;
  logic [PITCH_W-1:0]         den;
  logic [NUM_W-1:0]           num;
  logic [AMOUNT_W+SPAN_W-1:0] damp_prod;
  logic [DAMP_W-1:0]          damp_calc;

  assign den       = (pitch > PITCH_FLOOR) ? pitch : PITCH_FLOOR;
  assign num       = {1'b0, rate_hz, 4'b0000} + NUM_W'(den[PITCH_W-1:1]);
  assign damp_prod = amount * DAMP_SPAN;
  assign damp_calc = DAMP_BASE + DAMP_W'(damp_prod[AMOUNT_W+SPAN_W-1:AMOUNT_W]);
  assign accept    = request.valid && request.ready;
  assign start     = accept && (op_t'(request.operation) == OP_LOAD)
                     && request.first_of_excitation;

  psdl_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      FRONT_PASS: begin
        if (start) begin
          state_next = FRONT_DIV;
        end
      end
      FRONT_DIV: begin
        if (!div_busy) begin
          state_next = FRONT_PASS;
        end
      end
      default: state_next = FRONT_PASS;
    endcase
  end

  always_comb begin
    request.ready = 1'b0;
    push          = 1'b0;
    case (state)
      FRONT_PASS: begin
        request.ready = !clear_busy && (!held_valid || !q_full);
        push          = held_valid && !q_full;
      end
      FRONT_DIV: begin
        request.ready = 1'b0;
        push          = 1'b0;
      end
      default: begin
        request.ready = 1'b0;
        push          = 1'b0;
      end
    endcase
  end

  assign push_item.op       = held_op;
  assign push_item.first    = held_first;
  assign push_item.sample   = held_sample;
  assign push_item.quotient = div_quo;
  assign push_item.damping  = held_damp;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FRONT_PASS;
      held_valid <= 1'b0;
      rate_hz    <= RATE_RESET;
      pitch      <= PITCH_RESET;
      amount     <= AMOUNT_RESET;
    end else begin
      state <= state_next;
      if (accept) begin
        held_valid <= 1'b1;
      end else if (push) begin
        held_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_RATE_HZ: rate_hz <= cfg_data[RATE_W-1:0];
          CFG_PITCH:   pitch   <= cfg_data[PITCH_W-1:0];
          CFG_DAMPING: amount  <= cfg_data[AMOUNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_op     <= op_t'(request.operation);
      held_first  <= request.first_of_excitation;
      held_sample <= request.excitation_sample;
      held_damp   <= damp_calc;
    end
  end

endmodule

[hdl/psdl_back.sv]
// ----------------------------------------------------------------------------
// psdl_back
// Runs queued items against the delay store: excitation writes and ticks.
// ----------------------------------------------------------------------------
module psdl_back import psdl_pkg::*; #(
  parameter int DELAY_DEPTH = DEFAULT_DELAY_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  psdl_item_t q_item,
  output logic       pop,
  output logic       clear_busy,
  psdl_out_if.source result
);

  localparam int AW  = $clog2(DELAY_DEPTH);
  localparam int LIW = AW + 1;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic [AW-1:0]    MIN_LEN   = AW'(MIN_LOOP_LENGTH);
  localparam logic [QUO_W-1:0] MIN_LEN_Q = QUO_W'(MIN_LOOP_LENGTH);
  localparam logic [QUO_W-1:0] MAX_LEN_Q = QUO_W'(DELAY_DEPTH - 1);
  localparam logic [LIW-1:0]   INDEX_CAP = LIW'(DELAY_DEPTH);

  back_state_t                state;
  back_state_t                state_next;
  logic [AW-1:0]              clear_addr;
  logic [AW-1:0]              length;
  logic [AW-1:0]              pos;
  logic [LIW-1:0]             load_index;
  logic [DAMP_W-1:0]          damp;
  logic signed [SAMPLE_W-1:0] cur;
  logic signed [32:0]         prod;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;

  logic                       is_load;
  logic                       short_loop;
  logic                       out_free;
  logic [AW-1:0]              pluck_len;
  logic [AW-1:0]              eff_len;
  logic [LIW-1:0]             eff_idx;
  logic                       load_hit;
  logic [AW-1:0]              pos_inc;
  logic [AW-1:0]              nx;
  logic [SAMPLE_W-1:0]        rd_cur;
  logic [SAMPLE_W-1:0]        rd_nx;
  logic signed [SAMPLE_W:0]   sum;
  logic signed [SAMPLE_W-1:0] avg;
  logic signed [DAMP_W:0]     damp_s;
  logic signed [32:0]         prod_next;
  logic signed [32:0]         rnd;
  logic [SAMPLE_W:0]          rnd_hi;
  logic [SAMPLE_W-1:0]        wb;
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [SAMPLE_W-1:0]        ram_wdata;
  logic                       emit;
  logic signed [SAMPLE_W-1:0] emit_sample;

  assign is_load    = q_item.op == OP_LOAD;
  assign short_loop = length < MIN_LEN;
  assign out_free   = !out_valid || result.ready;

  always_comb begin
    if (q_item.quotient < MIN_LEN_Q) begin
      pluck_len = MIN_LEN;
    end else if (q_item.quotient > MAX_LEN_Q) begin
      pluck_len = LAST_ADDR;
    end else begin
      pluck_len = q_item.quotient[AW-1:0];
    end
  end

  assign eff_len  = q_item.first ? pluck_len : length;
  assign eff_idx  = q_item.first ? '0 : load_index;
  assign load_hit = eff_idx < {1'b0, eff_len};

  assign pos_inc = pos + 1'b1;
  assign nx      = (pos_inc < length) ? pos_inc : '0;

  // damped average of the two neighbors, rounded half up
  assign sum       = {rd_cur[SAMPLE_W-1], rd_cur} + {rd_nx[SAMPLE_W-1], rd_nx};
  assign avg       = sum[SAMPLE_W:1];
  assign damp_s    = {1'b0, damp};
  assign prod_next = avg * damp_s;
  assign rnd       = prod + 33'sd32768;
  assign rnd_hi    = rnd[32:16];
  assign wb        = (rnd_hi[SAMPLE_W] != rnd_hi[SAMPLE_W-1])
                     ? {rnd_hi[SAMPLE_W], {(SAMPLE_W-1){~rnd_hi[SAMPLE_W]}}}
                     : rnd_hi[SAMPLE_W-1:0];

  psdl_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (pos),
    .rdata_a (rd_cur),
    .raddr_b (nx),
    .rdata_b (rd_nx)
  );

  always_comb begin
    state_next = state;
    case (state)
      BACK_CLEAR: begin
        if (clear_addr == LAST_ADDR) begin
          state_next = BACK_IDLE;
        end
      end
      BACK_IDLE: begin
        if (!q_empty && !is_load && !short_loop) begin
          state_next = BACK_READ;
        end
      end
      BACK_READ: state_next = BACK_WRITE;
      BACK_WRITE: begin
        if (out_free) begin
          state_next = BACK_IDLE;
        end
      end
      default: state_next = BACK_IDLE;
    endcase
  end

  always_comb begin
    pop         = 1'b0;
    clear_busy  = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = pos;
    ram_wdata   = wb;
    emit        = 1'b0;
    emit_sample = cur;
    case (state)
      BACK_CLEAR: begin
        clear_busy = 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = clear_addr;
        ram_wdata  = '0;
      end
      BACK_IDLE: begin
        if (!q_empty) begin
          if (is_load) begin
            pop       = 1'b1;
            ram_we    = load_hit;
            ram_waddr = eff_idx[AW-1:0];
            ram_wdata = q_item.sample;
          end else if (short_loop) begin
            pop         = out_free;
            emit        = out_free;
            emit_sample = '0;
          end else begin
            pop = 1'b1;
          end
        end
      end
      BACK_READ: begin
        pop = 1'b0;
      end
      BACK_WRITE: begin
        ram_we = out_free;
        emit   = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BACK_CLEAR;
      clear_addr <= '0;
      length     <= '0;
      pos        <= '0;
      load_index <= '0;
      damp       <= DAMP_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == BACK_CLEAR) begin
        clear_addr <= clear_addr + 1'b1;
      end
      if (pop && is_load) begin
        if (q_item.first) begin
          length <= pluck_len;
          damp   <= q_item.damping;
          pos    <= '0;
        end
        load_index <= (eff_idx < INDEX_CAP) ? eff_idx + 1'b1 : eff_idx;
      end
      if (state == BACK_WRITE && out_free) begin
        pos <= nx;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == BACK_READ) begin
      cur  <= rd_cur;
      prod <= prod_next;
    end
    if (emit) begin
      out_sample <= emit_sample;
    end
  end

  assign result.valid         = out_valid;
  assign result.string_sample = out_sample;

endmodule

[hdl/plucked_string_delay_line_top.sv]
// ----------------------------------------------------------------------------
// plucked_string_delay_line_top
// Karplus-Strong plucked string: front, item queue and delay store back end.
// ----------------------------------------------------------------------------
// path: a tick goes through the held register, the queue, IDLE, READ and WRITE
// ticks: one at a time in the back end (read, multiply, write back on the store)
// loads: one per cycle while the queue has room; a pluck start holds the input (divider)
// reset: synchronous; the store is zeroed in a sweep after reset,
// no item accepted during the sweep, register writes still taken
// ----------------------------------------------------------------------------
module plucked_string_delay_line_top import psdl_pkg::*; #(
  parameter int DELAY_DEPTH = DEFAULT_DELAY_DEPTH,
  parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  psdl_in_if.sink              request,
  psdl_out_if.source           result,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic       clear_busy;
  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  psdl_item_t push_item;
  psdl_item_t q_item;

  psdl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .request    (request),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .clear_busy (clear_busy),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  psdl_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (q_item),
    .empty     (q_empty)
  );

  psdl_back #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .pop        (pop),
    .clear_busy (clear_busy),
    .result     (result)
  );

endmodule
